// ----- src/assert_macros.svh -----
// Assertion macros shared by the sliding median filter checkers.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge, skipped while reset is low.
`define SMF_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Check prop on every rising edge, reset included.
`define SMF_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- src/smf_pkg.sv -----
// Shared constants, types and helpers of the sliding median filter.
// No dependencies; imported by every module of the block.
package smf_pkg;

  localparam int MAX_WINDOW_DEF  = 15;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WIN_REG_BITS    = 4;
  localparam int WIN_MIN         = 3;
  localparam int WIN_RESET       = 3;
  localparam int REG_WINDOW_SIZE = 0;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic int clamp_window(input int raw, input int max_win);
    int w;
    w = raw;
    if (w < WIN_MIN) w = WIN_MIN;
    if (w > max_win) w = max_win;
    if ((w % 2) == 0) begin
      w = w + 1;
      if (w > max_win) w = max_win;
    end
    return w;
  endfunction

endpackage

// ----- src/smf_cell.sv -----
// One cell of the sorted sample row: value, age and valid bit.
// Depends on smf_pkg; instantiated by sliding_median_filter_top.
module smf_cell import smf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int AGE_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic                          up_valid,
  input  logic        [AGE_W-1:0]       up_age,
  input  logic signed [SAMPLE_BITS-1:0] up_value,
  input  logic                          lo_valid,
  input  logic        [AGE_W-1:0]       lo_age,
  input  logic signed [SAMPLE_BITS-1:0] lo_value,
  input  logic                          lo_gt,
  output logic                          st_valid,
  output logic        [AGE_W-1:0]       st_age,
  output logic signed [SAMPLE_BITS-1:0] st_value,
  output logic                          mid_valid,
  output logic        [AGE_W-1:0]       mid_age,
  output logic signed [SAMPLE_BITS-1:0] mid_value,
  output logic                          gt,
  output logic signed [SAMPLE_BITS-1:0] nxt_value
);

  logic                          valid_r;
  logic        [AGE_W-1:0]       age_r;
  logic signed [SAMPLE_BITS-1:0] value_r;
  logic                          valid_nxt;
  logic        [AGE_W-1:0]       age_nxt;

  always_comb begin
    mid_valid = ctl.shift ? up_valid : valid_r;
    mid_age   = (ctl.shift ? up_age : age_r) + AGE_W'(1);
    mid_value = ctl.shift ? up_value : value_r;
    gt        = !mid_valid || (mid_value > x);
    if (gt && lo_gt) begin
      valid_nxt = lo_valid;
      age_nxt   = lo_age;
      nxt_value = lo_value;
    end else if (gt) begin
      valid_nxt = 1'b1;
      age_nxt   = '0;
      nxt_value = x;
    end else begin
      valid_nxt = mid_valid;
      age_nxt   = mid_age;
      nxt_value = mid_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      age_r   <= age_nxt;
      value_r <= nxt_value;
    end
  end

  assign st_valid = valid_r;
  assign st_age   = age_r;
  assign st_value = value_r;

endmodule

// ----- src/sliding_median_filter_top.sv -----
// Top level of the sliding median filter: cell row, window control, ports.
// Depends on smf_pkg and smf_cell.
//
// Takes one item per clock while out_tready is high and returns one median
// item per input item in the next cycle via an output register. A row of
// MAX_WINDOW cells keeps the held samples in sorted order with ages; each
// accepted item drops the oldest sample (once the window is full) and
// inserts the new one in a single compare-and-shift step across the row,
// so the sustained rate is one item per cycle. Writing window_size clears
// the row at once through per-cell valid bits; no clearing pass is needed.
module sliding_median_filter_top import smf_pkg::*; #(
  parameter  int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] median
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W = $clog2(MAX_WINDOW);
  localparam int IDX_W = $clog2(MAX_WINDOW);

  logic        [LEN_W-1:0]       win_len_r;
  logic        [LEN_W-1:0]       count_r;
  logic        [LEN_W-1:0]       count_nxt;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic                          accept;
  logic                          cfg_wr;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] x;
  logic        [AGE_W-1:0]       oldest_age;
  logic        [MAX_WINDOW-1:0]  del;
  logic                          del_any;
  logic        [IDX_W-1:0]       del_idx;
  logic        [IDX_W-1:0]       med_idx;
  logic signed [SAMPLE_BITS-1:0] med_value;

  cell_ctl_t                     ctl       [MAX_WINDOW];
  logic                          st_valid  [MAX_WINDOW];
  logic        [AGE_W-1:0]       st_age    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] st_value  [MAX_WINDOW];
  logic                          mid_valid [MAX_WINDOW];
  logic        [AGE_W-1:0]       mid_age   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] mid_value [MAX_WINDOW];
  logic                          gt        [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] nxt_value [MAX_WINDOW];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_ADDR_W-1] == 1'(REG_WINDOW_SIZE));
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(win_len_r);
  assign x          = in_tdata[SAMPLE_BITS-1:0];
  assign full       = (count_r == win_len_r);
  assign count_nxt  = full ? count_r : count_r + LEN_W'(1);
  assign oldest_age = AGE_W'(win_len_r - LEN_W'(1));
  assign med_idx    = IDX_W'(count_nxt >> 1);

  always_comb begin
    del_idx = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      del[i] = full && st_valid[i] && (st_age[i] == oldest_age);
      if (del[i]) del_idx = del_idx | IDX_W'(i);
    end
    del_any = |del;
  end

  always_comb begin
    med_value = nxt_value[0];
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (med_idx == IDX_W'(i)) med_value = nxt_value[i];
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          up_valid;
    logic        [AGE_W-1:0]       up_age;
    logic signed [SAMPLE_BITS-1:0] up_value;
    logic                          lo_valid;
    logic        [AGE_W-1:0]       lo_age;
    logic signed [SAMPLE_BITS-1:0] lo_value;
    logic                          lo_gt;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_age   = '0;
      assign up_value = '0;
    end else begin : g_mid
      assign up_valid = st_valid[i+1];
      assign up_age   = st_age[i+1];
      assign up_value = st_value[i+1];
    end

    if (i == 0) begin : g_bot
      assign lo_valid = 1'b0;
      assign lo_age   = '0;
      assign lo_value = '0;
      assign lo_gt    = 1'b0;
    end else begin : g_lo
      assign lo_valid = mid_valid[i-1];
      assign lo_age   = mid_age[i-1];
      assign lo_value = mid_value[i-1];
      assign lo_gt    = gt[i-1];
    end

    assign ctl[i].clear = cfg_wr;
    assign ctl[i].load  = accept;
    assign ctl[i].shift = del_any && (IDX_W'(i) >= del_idx);

    smf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_W      (AGE_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[i]),
      .x        (x),
      .up_valid (up_valid),
      .up_age   (up_age),
      .up_value (up_value),
      .lo_valid (lo_valid),
      .lo_age   (lo_age),
      .lo_value (lo_value),
      .lo_gt    (lo_gt),
      .st_valid (st_valid[i]),
      .st_age   (st_age[i]),
      .st_value (st_value[i]),
      .mid_valid(mid_valid[i]),
      .mid_age  (mid_age[i]),
      .mid_value(mid_value[i]),
      .gt       (gt[i]),
      .nxt_value(nxt_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= LEN_W'(clamp_window(WIN_RESET, MAX_WINDOW));
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        win_len_r <= LEN_W'(clamp_window(int'(cfg_pwdata[WIN_REG_BITS-1:0]), MAX_WINDOW));
        count_r   <= '0;
      end else if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= med_value;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($unsigned(out_data_r));

endmodule

// ----- src/smf_checker.sv -----
// Port-level checks of the sliding median filter, bound to the top level.
// Depends on smf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smf_checker import smf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int TDATA_W    = SAMPLE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata
);

  `SMF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled item changed")
  `SMF_ASSERT(a_in_to_out, clk, rst_n, in_tvalid && in_tready |=> out_tvalid, "accepted item gave no result")
  `SMF_ASSERT(a_ready_free, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")
  `SMF_ASSERT(a_win_range, clk, rst_n, (cfg_prdata >= CFG_DATA_W'(WIN_MIN)) && (cfg_prdata <= CFG_DATA_W'(MAX_WINDOW)), "window length out of range")
  `SMF_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_tvalid, "result shown after reset")

endmodule

bind sliding_median_filter_top smf_checker #(
  .MAX_WINDOW(MAX_WINDOW),
  .TDATA_W   (TDATA_W)
) u_smf_checker (.*);
